[rtl/assert_macros.svh]
//------------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when NO_ASSERTIONS is defined.
//------------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define CHK_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define CHK_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define CHK_IMPL(name, clk, rst_n, ante, cons)
`define CHK_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

[rtl/lsq_pkg.sv]
//------------------------------------------------------------------------------
// lsq_pkg
// Shared widths, types and step functions of the segment-to-quad expander.
//------------------------------------------------------------------------------
package lsq_pkg;

    localparam int COORD_BITS  = 24;
    localparam int HW_BITS     = 20;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int SHIFT_BITS  = $clog2(DIFF_BITS);
    localparam int NORM_BITS   = 15;              // normalized max in [2^14, 2^15)
    localparam int NORM_MSB    = NORM_BITS - 1;
    localparam int SQ_BITS     = 2 * NORM_BITS;
    localparam int LEN_BITS    = SQ_BITS + 1;
    localparam int LANE_BITS   = 34;
    localparam int DIV_STEPS   = 32;
    localparam int SQRT_STEPS  = 17;
    localparam int UNIT_STAGES = 1 + DIV_STEPS + SQRT_STEPS;
    localparam int UNIT_BITS   = SQRT_STEPS;      // unit component, at most 2^16
    localparam int RND_SHIFT   = 16;
    localparam int PROD_BITS   = UNIT_BITS + HW_BITS + 1;
    localparam int MAG_BITS    = HW_BITS + 1;
    localparam int OFS_BITS    = MAG_BITS + 1;
    localparam int SUM_BITS    = ((COORD_BITS > OFS_BITS) ? COORD_BITS : OFS_BITS) + 1;

    localparam int CFG_IDX_BITS = 8;
    localparam logic [CFG_IDX_BITS-1:0] REG_HALF_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_DEPTH_LAYER = CFG_IDX_BITS'(1);
    localparam logic [HW_BITS-1:0]      HALF_WIDTH_RST  = HW_BITS'(4096);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        CORNER_SM = 2'd0,
        CORNER_SP = 2'd1,
        CORNER_EP = 2'd2,
        CORNER_EM = 2'd3
    } corner_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] sx;
        logic signed [COORD_BITS-1:0] sy;
        logic signed [COORD_BITS-1:0] ex;
        logic signed [COORD_BITS-1:0] ey;
        logic                         neg_dx;
        logic                         pos_dy;
        logic                         degen;
    } seg_t;

    typedef struct packed {
        seg_t                seg;
        logic [SQ_BITS-1:0]  ax2;
        logic [SQ_BITS-1:0]  ay2;
        logic [LEN_BITS-1:0] len2;
    } job_t;

    // divide phase: acc = quotient, rem = remainder
    // root phase:   acc = radicand left, rem = root
    typedef struct packed {
        logic [LANE_BITS-1:0] acc;
        logic [LANE_BITS-1:0] rem;
    } lane_t;

    typedef struct packed {
        seg_t                seg;
        logic [LEN_BITS-1:0] len2;
        lane_t               lox;   // from ay2, feeds x offset
        lane_t               loy;   // from ax2, feeds y offset
    } work_t;

    function automatic lane_t div_init(logic [SQ_BITS-1:0] a2, logic [LEN_BITS-1:0] len2);
        lane_t o;
        logic [LANE_BITS-1:0] n;
        logic [LANE_BITS-1:0] d;
        n = LANE_BITS'(a2);
        d = LANE_BITS'(len2);
        o.acc = '0;
        o.rem = n;
        if (n >= d) begin
            o.acc = LANE_BITS'(1);
            o.rem = n - d;
        end
        return o;
    endfunction

    function automatic lane_t div_step(lane_t i, logic [LEN_BITS-1:0] len2);
        lane_t o;
        logic [LANE_BITS-1:0] r2;
        logic [LANE_BITS-1:0] d;
        d     = LANE_BITS'(len2);
        r2    = {i.rem[LANE_BITS-2:0], 1'b0};
        o.acc = {i.acc[LANE_BITS-2:0], 1'b0};
        o.rem = r2;
        if (r2 >= d) begin
            o.acc[0] = 1'b1;
            o.rem    = r2 - d;
        end
        return o;
    endfunction

    function automatic lane_t sqrt_init(lane_t i);
        lane_t o;
        o.acc = i.acc;
        o.rem = '0;
        return o;
    endfunction

    function automatic lane_t sqrt_step(lane_t i, int k);
        lane_t o;
        logic [LANE_BITS-1:0] b;
        logic [LANE_BITS-1:0] t;
        b = LANE_BITS'(1) << (2 * k);
        t = i.rem + b;
        if (i.acc >= t) begin
            o.acc = i.acc - t;
            o.rem = (i.rem >> 1) + b;
        end else begin
            o.acc = i.acc;
            o.rem = i.rem >> 1;
        end
        return o;
    endfunction

endpackage

[rtl/lsq_front.sv]
//------------------------------------------------------------------------------
// lsq_front
// Accepts segments, classifies them and builds the normalized squares.
//------------------------------------------------------------------------------
module lsq_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [lsq_pkg::COORD_BITS-1:0] in_sx,
    input  logic signed [lsq_pkg::COORD_BITS-1:0] in_sy,
    input  logic signed [lsq_pkg::COORD_BITS-1:0] in_ex,
    input  logic signed [lsq_pkg::COORD_BITS-1:0] in_ey,
    output logic                            out_valid,
    input  logic                            out_ready,
    output lsq_pkg::job_t                   out_job
);
    import lsq_pkg::*;

    logic en;
    logic v1_reg, v2_reg, v3_reg;
    seg_t seg1_reg, seg2_reg;
    logic [DIFF_BITS-1:0]  ax1_reg, ay1_reg;
    logic [SHIFT_BITS-1:0] msb1_reg;
    logic [NORM_BITS-1:0]  nx2_reg, ny2_reg;
    job_t job3_reg;

    logic signed [DIFF_BITS-1:0] dx, dy;
    logic [DIFF_BITS-1:0]  ax, ay, mag_or;
    logic [SHIFT_BITS-1:0] msb;
    seg_t                  seg0;
    logic [NORM_BITS-1:0]  nx, ny;
    logic [SQ_BITS-1:0]    ax2, ay2;

    assign en        = !v3_reg || out_ready;
    assign in_ready  = en;
    assign out_valid = v3_reg;
    assign out_job   = job3_reg;

    // stage 1: differences, magnitudes, leading-one position
    always_comb begin
        dx = DIFF_BITS'(in_ex) - DIFF_BITS'(in_sx);
        dy = DIFF_BITS'(in_ey) - DIFF_BITS'(in_sy);
        ax = dx[DIFF_BITS-1] ? DIFF_BITS'(-dx) : DIFF_BITS'(dx);
        ay = dy[DIFF_BITS-1] ? DIFF_BITS'(-dy) : DIFF_BITS'(dy);
        mag_or = ax | ay;
        msb = '0;
        for (int i = 0; i < DIFF_BITS; i++) begin
            if (mag_or[i]) msb = SHIFT_BITS'(i);
        end
        seg0.sx     = in_sx;
        seg0.sy     = in_sy;
        seg0.ex     = in_ex;
        seg0.ey     = in_ey;
        seg0.neg_dx = dx[DIFF_BITS-1];
        seg0.pos_dy = !dy[DIFF_BITS-1] && (dy != '0);
        seg0.degen  = (dx == '0) && (dy == '0);
    end

    // stage 2: shift max into [2^14, 2^15)
    always_comb begin
        if (msb1_reg >= SHIFT_BITS'(NORM_MSB)) begin
            nx = NORM_BITS'(ax1_reg >> (msb1_reg - SHIFT_BITS'(NORM_MSB)));
            ny = NORM_BITS'(ay1_reg >> (msb1_reg - SHIFT_BITS'(NORM_MSB)));
        end else begin
            nx = NORM_BITS'(ax1_reg << (SHIFT_BITS'(NORM_MSB) - msb1_reg));
            ny = NORM_BITS'(ay1_reg << (SHIFT_BITS'(NORM_MSB) - msb1_reg));
        end
    end

    // stage 3: squares and squared length
    assign ax2 = nx2_reg * nx2_reg;
    assign ay2 = ny2_reg * ny2_reg;

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            seg1_reg      <= seg0;
            ax1_reg       <= ax;
            ay1_reg       <= ay;
            msb1_reg      <= msb;
            seg2_reg      <= seg1_reg;
            nx2_reg       <= nx;
            ny2_reg       <= ny;
            job3_reg.seg  <= seg2_reg;
            job3_reg.ax2  <= ax2;
            job3_reg.ay2  <= ay2;
            job3_reg.len2 <= LEN_BITS'(ax2) + LEN_BITS'(ay2);
        end
    end

endmodule

[rtl/lsq_queue.sv]
//------------------------------------------------------------------------------
// lsq_queue
// Short job queue between the front and the back.
//------------------------------------------------------------------------------
module lsq_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  lsq_pkg::job_t in_job,
    output logic          out_valid,
    input  logic          out_ready,
    output lsq_pkg::job_t out_job
);
    import lsq_pkg::*;

    job_t                 mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_BITS:0]   count_reg, count_next;
    logic                 push, pop;

    assign in_ready  = count_reg != (QPTR_BITS+1)'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_job   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + 1'b1;
        if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push) mem_reg[wr_ptr_reg] <= in_job;
    end

endmodule

[rtl/lsq_unit.sv]
//------------------------------------------------------------------------------
// lsq_unit
// Pipelined restoring divide and square root, one bit per stage, two lanes.
//------------------------------------------------------------------------------
module lsq_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  lsq_pkg::job_t                     in_job,
    output logic                              out_valid,
    input  logic                              out_ready,
    output lsq_pkg::seg_t                     out_seg,
    output logic [lsq_pkg::UNIT_BITS-1:0]     out_ux,
    output logic [lsq_pkg::UNIT_BITS-1:0]     out_uy
);
    import lsq_pkg::*;

    logic                   en;
    logic [UNIT_STAGES-1:0] valid_reg;
    work_t                  stage_reg  [UNIT_STAGES];
    work_t                  stage_next [UNIT_STAGES];

    assign en        = !valid_reg[UNIT_STAGES-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = valid_reg[UNIT_STAGES-1];
    assign out_seg   = stage_reg[UNIT_STAGES-1].seg;
    assign out_ux    = stage_reg[UNIT_STAGES-1].lox.rem[UNIT_BITS-1:0];
    assign out_uy    = stage_reg[UNIT_STAGES-1].loy.rem[UNIT_BITS-1:0];

    for (genvar j = 0; j < UNIT_STAGES; j++) begin : g_stage
        if (j == 0) begin : g_init
            always_comb begin
                stage_next[j].seg  = in_job.seg;
                stage_next[j].len2 = in_job.len2;
                stage_next[j].lox  = div_init(in_job.ay2, in_job.len2);
                stage_next[j].loy  = div_init(in_job.ax2, in_job.len2);
            end
        end else if (j <= DIV_STEPS) begin : g_div
            always_comb begin
                stage_next[j]     = stage_reg[j-1];
                stage_next[j].lox = div_step(stage_reg[j-1].lox, stage_reg[j-1].len2);
                stage_next[j].loy = div_step(stage_reg[j-1].loy, stage_reg[j-1].len2);
            end
        end else if (j == DIV_STEPS + 1) begin : g_root_first
            always_comb begin
                stage_next[j]     = stage_reg[j-1];
                stage_next[j].lox = sqrt_step(sqrt_init(stage_reg[j-1].lox), UNIT_STAGES-1-j);
                stage_next[j].loy = sqrt_step(sqrt_init(stage_reg[j-1].loy), UNIT_STAGES-1-j);
            end
        end else begin : g_root
            always_comb begin
                stage_next[j]     = stage_reg[j-1];
                stage_next[j].lox = sqrt_step(stage_reg[j-1].lox, UNIT_STAGES-1-j);
                stage_next[j].loy = sqrt_step(stage_reg[j-1].loy, UNIT_STAGES-1-j);
            end
        end

        always_ff @(posedge clk) begin
            if (en) stage_reg[j] <= stage_next[j];
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[UNIT_STAGES-2:0], in_valid};
        end
    end

endmodule

[rtl/lsq_emit.sv]
//------------------------------------------------------------------------------
// lsq_emit
// Scales the unit vector, then issues the four saturated corners in order.
//------------------------------------------------------------------------------
module lsq_emit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  lsq_pkg::seg_t                         in_seg,
    input  logic [lsq_pkg::UNIT_BITS-1:0]         in_ux,
    input  logic [lsq_pkg::UNIT_BITS-1:0]         in_uy,
    input  logic [lsq_pkg::HW_BITS-1:0]           half_width,
    input  logic signed [lsq_pkg::COORD_BITS-1:0] depth_layer,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [lsq_pkg::COORD_BITS-1:0] out_x,
    output logic signed [lsq_pkg::COORD_BITS-1:0] out_y,
    output logic signed [lsq_pkg::COORD_BITS-1:0] out_z,
    output lsq_pkg::corner_t                      out_corner,
    output logic                                  out_last,
    output logic                                  out_degen
);
    import lsq_pkg::*;

    // scale stage
    logic                       mv_reg;
    seg_t                       mseg_reg;
    logic signed [OFS_BITS-1:0] mox_reg, moy_reg;
    // corner holder
    logic                       hv_reg;
    seg_t                       hseg_reg;
    logic signed [OFS_BITS-1:0] hox_reg, hoy_reg;
    corner_t                    cnt_reg, cnt_next;
    // output register
    logic                         ov_reg;
    logic signed [COORD_BITS-1:0] ox_out_reg, oy_out_reg, oz_out_reg;
    corner_t                      oc_reg;
    logic                         olast_reg, odeg_reg;

    logic [PROD_BITS-1:0]         px, py;
    logic [MAG_BITS-1:0]          magx, magy;
    logic signed [OFS_BITS-1:0]   offx, offy;
    logic                         out_load, hold_free, m_take;
    logic signed [COORD_BITS-1:0] bx, by;
    logic signed [SUM_BITS-1:0]   sumx, sumy;
    logic                         plus;

    function automatic logic signed [COORD_BITS-1:0] sat(logic signed [SUM_BITS-1:0] v);
        if (v > SUM_BITS'(COORD_MAX)) return COORD_MAX;
        if (v < SUM_BITS'(COORD_MIN)) return COORD_MIN;
        return COORD_BITS'(v);
    endfunction

    // magnitude = (u * half_width + 2^15) >> 16, signed by direction
    always_comb begin
        px   = PROD_BITS'(in_ux) * PROD_BITS'(half_width)
             + (PROD_BITS'(1) << (RND_SHIFT - 1));
        py   = PROD_BITS'(in_uy) * PROD_BITS'(half_width)
             + (PROD_BITS'(1) << (RND_SHIFT - 1));
        magx = px[RND_SHIFT +: MAG_BITS];
        magy = py[RND_SHIFT +: MAG_BITS];
        offx = signed'({1'b0, magx});
        offy = signed'({1'b0, magy});
        if (in_seg.pos_dy) offx = -offx;
        if (in_seg.neg_dx) offy = -offy;
        if (in_seg.degen) begin
            offx = '0;
            offy = '0;
        end
    end

    assign out_load  = hv_reg && (!ov_reg || out_ready);
    assign hold_free = !hv_reg || (out_load && (cnt_reg == CORNER_EM));
    assign m_take    = mv_reg && hold_free;
    assign in_ready  = !mv_reg || m_take;

    always_comb begin
        unique case (cnt_reg)
            CORNER_SM: cnt_next = CORNER_SP;
            CORNER_SP: cnt_next = CORNER_EP;
            CORNER_EP: cnt_next = CORNER_EM;
            CORNER_EM: cnt_next = CORNER_SM;
            default:   cnt_next = CORNER_SM;
        endcase
    end

    always_comb begin
        bx   = (cnt_reg == CORNER_SM || cnt_reg == CORNER_SP) ? hseg_reg.sx : hseg_reg.ex;
        by   = (cnt_reg == CORNER_SM || cnt_reg == CORNER_SP) ? hseg_reg.sy : hseg_reg.ey;
        plus = (cnt_reg == CORNER_SP || cnt_reg == CORNER_EP);
        sumx = plus ? SUM_BITS'(bx) + SUM_BITS'(hox_reg) : SUM_BITS'(bx) - SUM_BITS'(hox_reg);
        sumy = plus ? SUM_BITS'(by) + SUM_BITS'(hoy_reg) : SUM_BITS'(by) - SUM_BITS'(hoy_reg);
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            mv_reg  <= 1'b0;
            hv_reg  <= 1'b0;
            ov_reg  <= 1'b0;
            cnt_reg <= CORNER_SM;
        end else begin
            if (in_ready) mv_reg <= in_valid;
            if (hold_free) begin
                hv_reg <= mv_reg;
            end
            if (m_take) begin
                cnt_reg <= CORNER_SM;
            end else if (out_load) begin
                cnt_reg <= cnt_next;
            end
            if (out_load) begin
                ov_reg <= 1'b1;
            end else if (out_ready) begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (in_ready) begin
            mseg_reg <= in_seg;
            mox_reg  <= offx;
            moy_reg  <= offy;
        end
        if (m_take) begin
            hseg_reg <= mseg_reg;
            hox_reg  <= mox_reg;
            hoy_reg  <= moy_reg;
        end
        if (out_load) begin
            ox_out_reg <= sat(sumx);
            oy_out_reg <= sat(sumy);
            oz_out_reg <= depth_layer;
            oc_reg     <= cnt_reg;
            olast_reg  <= (cnt_reg == CORNER_EM);
            odeg_reg   <= hseg_reg.degen;
        end
    end

    assign out_valid  = ov_reg;
    assign out_x      = ox_out_reg;
    assign out_y      = oy_out_reg;
    assign out_z      = oz_out_reg;
    assign out_corner = oc_reg;
    assign out_last   = olast_reg;
    assign out_degen  = odeg_reg;

endmodule

[rtl/line_segment_to_quad_top.sv]
//------------------------------------------------------------------------------
// line_segment_to_quad_top
// Expands a line segment into the four corners of a stroked quad.
//------------------------------------------------------------------------------
// Usage:
//   s_t* carries one segment request per handshake; m_t* returns four corner
//   vertices per segment (start-minus, start-plus, end-plus, end-minus), the
//   fourth marked with m_tlast. cfg_* writes half_width (index 0) and
//   depth_layer (index 1); cfg_ready is always high, other indexes are ignored.
//   Write configuration only while no segment is in flight.
// Pipeline: 3 front stages, the queue, 50 divide/root stages, 1 scale stage,
//   1 corner stage and 1 output register lie between a segment and its corners.
// Throughput: set by the single output channel issuing one corner per cycle
//   while m_tready is high, four corners per segment; front and divide/root
//   pipeline take one segment per cycle unless stalled and run ahead into the queue.
// Reset: aresetn low empties all pipelines and the queue, half_width returns
//   to 1.0 (4096) and depth_layer to 0.
// Stall: when m_tready is low the output holds; the back pipeline stops, the
//   queue fills, then the front and finally s_tready drop.
//------------------------------------------------------------------------------
module line_segment_to_quad_top (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // segment requests
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [4*lsq_pkg::COORD_BITS-1:0]       s_tdata,  // start_x, start_y, end_x, end_y
    // corner vertices
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [3*lsq_pkg::COORD_BITS-1:0]       m_tdata,  // vert_x, vert_y, vert_z
    output logic [2:0]                             m_tuser,  // corner_index[1:0], degenerate
    output logic                                   m_tlast,  // last_corner
    // configuration writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [lsq_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [lsq_pkg::COORD_BITS-1:0]         cfg_data
);
    import lsq_pkg::*;

    logic [HW_BITS-1:0]           half_width_reg;
    logic signed [COORD_BITS-1:0] depth_layer_reg;

    logic                  front_valid, queue_ready;
    job_t                  front_job;
    logic                  queue_valid, unit_ready;
    job_t                  queue_job;
    logic                  unit_valid, emit_ready;
    seg_t                  unit_seg;
    logic [UNIT_BITS-1:0]  unit_ux, unit_uy;
    logic signed [COORD_BITS-1:0] vx, vy, vz;
    corner_t               corner;
    logic                  degen;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_width_reg  <= HALF_WIDTH_RST;
            depth_layer_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_HALF_WIDTH)  half_width_reg  <= cfg_data[HW_BITS-1:0];
            if (cfg_index == REG_DEPTH_LAYER) depth_layer_reg <= cfg_data;
        end
    end

    // front: differences, zero-length check, normalization, squares
    lsq_front u_front (
        .clk       (aclk),
        .rst_n     (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sx     (s_tdata[0*COORD_BITS +: COORD_BITS]),
        .in_sy     (s_tdata[1*COORD_BITS +: COORD_BITS]),
        .in_ex     (s_tdata[2*COORD_BITS +: COORD_BITS]),
        .in_ey     (s_tdata[3*COORD_BITS +: COORD_BITS]),
        .out_valid (front_valid),
        .out_ready (queue_ready),
        .out_job   (front_job)
    );

    // decoupling queue
    lsq_queue u_queue (
        .clk       (aclk),
        .rst_n     (aresetn),
        .in_valid  (front_valid),
        .in_ready  (queue_ready),
        .in_job    (front_job),
        .out_valid (queue_valid),
        .out_ready (unit_ready),
        .out_job   (queue_job)
    );

    // back: unit perpendicular through divide and square root
    lsq_unit u_unit (
        .clk       (aclk),
        .rst_n     (aresetn),
        .in_valid  (queue_valid),
        .in_ready  (unit_ready),
        .in_job    (queue_job),
        .out_valid (unit_valid),
        .out_ready (emit_ready),
        .out_seg   (unit_seg),
        .out_ux    (unit_ux),
        .out_uy    (unit_uy)
    );

    // back: scaling and corner issue
    lsq_emit u_emit (
        .clk         (aclk),
        .rst_n       (aresetn),
        .in_valid    (unit_valid),
        .in_ready    (emit_ready),
        .in_seg      (unit_seg),
        .in_ux       (unit_ux),
        .in_uy       (unit_uy),
        .half_width  (half_width_reg),
        .depth_layer (depth_layer_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_x       (vx),
        .out_y       (vy),
        .out_z       (vz),
        .out_corner  (corner),
        .out_last    (m_tlast),
        .out_degen   (degen)
    );

    assign m_tdata = {vz, vy, vx};
    assign m_tuser = {degen, corner};

    `include "assert_macros.svh"

    // corners of one quad leave back to back
    `CHK_NEXT(a_corner_step, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tuser[1:0] == ($past(m_tuser[1:0]) + 2'd1)))
    // a new quad always opens with the start-minus corner
    `CHK_NEXT(a_corner_wrap, aclk, aresetn, m_tvalid && m_tready && m_tlast, !m_tvalid || (m_tuser[1:0] == CORNER_SM))
    // last flag marks exactly the end-minus corner
    `CHK_IMPL(a_last_corner, aclk, aresetn, m_tvalid, m_tlast == (m_tuser[1:0] == CORNER_EM))

endmodule

[bench/line_segment_to_quad_top_tb.sv]
//------------------------------------------------------------------------------
// line_segment_to_quad_top_tb
// Self-checking bench for the segment-to-quad expander: random and directed
// segment requests, random output stalls, an in-bench corner predictor and
// a config sweep that includes the extreme register values.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_segment_to_quad_top_tb;
    import lsq_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int WATCHDOG = 20000;
    localparam int DRAIN = 80;          // a bit over the pipeline depth

    // last member sits in the low bits, so start_x lands in s_tdata[CB-1:0]
    typedef struct packed {
        logic signed [CB-1:0] ey, ex, sy, sx;
    } segment_t;

    typedef struct packed {
        logic signed [CB-1:0] x, y, z;
        corner_t              idx;
        logic                 last;
        logic                 degen;
    } vertex_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [4*CB-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [3*CB-1:0] m_tdata;
    logic [2:0] m_tuser;
    logic m_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CB-1:0] cfg_data = '0;

    line_segment_to_quad_top dut (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // predictor copy of the registers
    logic [HW_BITS-1:0]   pred_half_width = HALF_WIDTH_RST;
    logic signed [CB-1:0] pred_depth = '0;

    segment_t pending_segs[$];
    vertex_t  expected_corners[$];
    int  n_errors = 0;
    bit  no_idle = 1'b0;        // burst stretch with no bubbles on either side

    // accept seen at the last rising edge
    bit s_tready_seen = 1'b0;
    int idle_cycles = 0;

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        n_errors++;
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint offset_mag(input longint unsigned a, input longint unsigned l2);
        longint unsigned u;
        u = int_sqrt(((a * a) << 32) / l2);
        return longint'((u * pred_half_width + (64'd1 << 15)) >> 16);
    endfunction

    function automatic logic signed [CB-1:0] sat_coord(input longint v);
        longint hi, lo;
        hi = (longint'(1) << (CB - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return COORD_MAX;
        if (v < lo) return COORD_MIN;
        return v[CB-1:0];
    endfunction

    // expected four corners of one stroked quad
    task automatic predict_quad(input segment_t s);
        longint dx, dy, ox, oy, bx, by, sg;
        longint unsigned nx, ny, l2;
        vertex_t v;
        bit degen;
        dx = longint'(s.ex) - longint'(s.sx);
        dy = longint'(s.ey) - longint'(s.sy);
        nx = dx < 0 ? -dx : dx;
        ny = dy < 0 ? -dy : dy;
        degen = (nx == 0 && ny == 0);
        ox = 0;
        oy = 0;
        if (!degen) begin
            while ((nx > ny ? nx : ny) >= (64'd1 << 15)) begin
                nx >>= 1;
                ny >>= 1;
            end
            while ((nx > ny ? nx : ny) < (64'd1 << 14)) begin
                nx <<= 1;
                ny <<= 1;
            end
            l2 = nx * nx + ny * ny;
            ox = offset_mag(ny, l2);
            oy = offset_mag(nx, l2);
            if (dy > 0) ox = -ox;
            if (dx < 0) oy = -oy;
        end
        for (int k = 0; k < 4; k++) begin
            bx = (k < 2) ? longint'(s.sx) : longint'(s.ex);
            by = (k < 2) ? longint'(s.sy) : longint'(s.ey);
            sg = (k == 1 || k == 2) ? 1 : -1;
            v.x = sat_coord(bx + sg * ox);
            v.y = sat_coord(by + sg * oy);
            v.z = pred_depth;
            v.idx = corner_t'(k);
            v.last = (k == 3);
            v.degen = degen;
            expected_corners.push_back(v);
        end
    endtask

    // driver: pops segments, presents them at the falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready_seen) begin
                if (pending_segs.size() > 0 && (no_idle || $urandom_range(99) >= 37)) begin
                    s_tdata <= pending_segs.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= no_idle || $urandom_range(99) >= 37;
        end
    end

    // monitor: segment accept feeds the predictor, corners are checked
    always @(posedge aclk) begin
        vertex_t got, exp_v;
        s_tready_seen <= s_tvalid && s_tready;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (s_tvalid && s_tready) begin
                predict_quad(segment_t'(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                got.x = m_tdata[CB-1:0];
                got.y = m_tdata[2*CB-1:CB];
                got.z = m_tdata[3*CB-1:2*CB];
                got.idx = corner_t'(m_tuser[1:0]);
                got.degen = m_tuser[2];
                got.last = m_tlast;
                if (expected_corners.size() == 0) begin
                    report_mismatch("corner with no pending quad");
                end else begin
                    exp_v = expected_corners.pop_front();
                    if (got.x !== exp_v.x)
                        report_mismatch($sformatf("x %0d exp %0d", got.x, exp_v.x));
                    if (got.y !== exp_v.y)
                        report_mismatch($sformatf("y %0d exp %0d", got.y, exp_v.y));
                    if (got.z !== exp_v.z)
                        report_mismatch($sformatf("z %0d exp %0d", got.z, exp_v.z));
                    if (got.idx !== exp_v.idx)
                        report_mismatch($sformatf("corner %0d exp %0d", got.idx, exp_v.idx));
                    if (got.last !== exp_v.last)
                        report_mismatch($sformatf("last %0b exp %0b", got.last, exp_v.last));
                    if (got.degen !== exp_v.degen)
                        report_mismatch($sformatf("degen %0b exp %0b", got.degen, exp_v.degen));
                end
            end
            if (idle_cycles >= WATCHDOG) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic logic signed [CB-1:0] rnd_coord();
        case ($urandom_range(5))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return CB'($signed($urandom_range(8191)) - 4096);
            default: return CB'($urandom);
        endcase
    endfunction

    function automatic segment_t rnd_segment();
        segment_t s;
        int unsigned kind;
        s.sx = rnd_coord();
        s.sy = rnd_coord();
        kind = $urandom_range(9);
        if (kind == 0) begin
            s.ex = s.sx;            // zero length
            s.ey = s.sy;
        end else if (kind < 4) begin
            // short segment near the start, incl. axis-aligned cases
            s.ex = s.sx + CB'($signed($urandom_range(200)) - 100);
            s.ey = (kind == 1) ? s.sy : s.sy + CB'($signed($urandom_range(200)) - 100);
        end else begin
            s.ex = rnd_coord();
            s.ey = rnd_coord();
        end
        return s;
    endfunction

    // hold until every expected corner is out, then let the pipeline settle
    task automatic wait_drained();
        while (pending_segs.size() > 0 || s_tvalid || expected_corners.size() > 0)
            @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CB-1:0] val);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_HALF_WIDTH) pred_half_width = val[HW_BITS-1:0];
        else if (idx == REG_DEPTH_LAYER) pred_depth = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic segment_t mkseg(input int sx, sy, ex, ey);
        segment_t s;
        s.sx = CB'(sx);
        s.sy = CB'(sy);
        s.ex = CB'(ex);
        s.ey = CB'(ey);
        return s;
    endfunction

    initial begin
        logic [HW_BITS-1:0] hw_set[4];
        logic signed [CB-1:0] z_set[4];
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: reset registers, degenerate, axis directions, extremes
        pending_segs.push_back(mkseg(0, 0, 0, 0));
        pending_segs.push_back(mkseg(100, 200, 100, 200));
        pending_segs.push_back(mkseg(0, 0, 4096, 0));
        pending_segs.push_back(mkseg(0, 0, -4096, 0));
        pending_segs.push_back(mkseg(0, 0, 0, 4096));
        pending_segs.push_back(mkseg(0, 0, 0, -4096));
        pending_segs.push_back(mkseg(0, 0, 1, 1));
        pending_segs.push_back(mkseg(-8388608, -8388608, 8388607, 8388607));
        pending_segs.push_back(mkseg(8388607, 8388607, -8388608, -8388608));
        pending_segs.push_back(mkseg(8388607, -8388608, 8388607, 8388607));
        pending_segs.push_back(mkseg(-8388608, 8388607, -8388608, -8388608));
        pending_segs.push_back(mkseg(8388607, 8388607, 8388607, 8388607));
        pending_segs.push_back(mkseg(-8388608, 0, 8388607, 1));
        wait_drained();

        // max half-width and depth extremes push corners into saturation
        write_reg(REG_HALF_WIDTH, CB'(20'hFFFFF));
        write_reg(REG_DEPTH_LAYER, COORD_MAX);
        pending_segs.push_back(mkseg(8388600, 8388600, 8388600, -8388600));
        pending_segs.push_back(mkseg(-8388600, -8388600, 8388600, -8388600));
        pending_segs.push_back(mkseg(0, 0, 3, -7));
        pending_segs.push_back(mkseg(5, 5, 5, 5));
        wait_drained();
        write_reg(REG_HALF_WIDTH, '0);
        write_reg(REG_DEPTH_LAYER, COORD_MIN);
        pending_segs.push_back(mkseg(0, 0, 4096, 4096));
        pending_segs.push_back(mkseg(-1, -1, 1, 1));
        wait_drained();

        // random phases over several register settings
        hw_set = '{20'd4096, 20'hFFFFF, 20'd1, 20'd0};
        z_set = '{CB'(0), COORD_MAX, COORD_MIN, CB'(-1)};
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_HALF_WIDTH, (ph < 4) ? CB'(hw_set[ph]) : CB'($urandom_range(20'hFFFFF)));
            write_reg(REG_DEPTH_LAYER, (ph < 4) ? z_set[ph] : CB'($urandom));
            no_idle = (ph == 2);
            for (int i = 0; i < 80; i++) pending_segs.push_back(rnd_segment());
            wait_drained();
        end
        no_idle = 1'b0;

        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
